>>> hdl/fixtvp_pkg.sv
// ----------------------------------------------------------------------------
// fixtvp_pkg
// Shared types and constants of the FIX tag=value field parser: character
// codes, special tags, saturation limits, parser state and result records.
// ----------------------------------------------------------------------------
package fixtvp_pkg;

  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int MAX_FIELDS        = 1024;

  localparam int POS_W = 12;
  localparam int CNT_W = 11;
  localparam int TAG_W = 17;
  localparam int NUM_W = 32;

  localparam int POS_CAP_INT = ((MAX_MESSAGE_BYTES - 1) < 4095) ? (MAX_MESSAGE_BYTES - 1) : 4095;
  localparam int CNT_CAP_INT = (MAX_FIELDS < 2047) ? MAX_FIELDS : 2047;

  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);
  localparam logic [POS_W-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

  localparam logic [7:0] CHAR_EQ    = 8'h3d;
  localparam logic [7:0] CHAR_SOH   = 8'h01;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [TAG_W-1:0] TAG_BEGIN    = 17'd8;
  localparam logic [TAG_W-1:0] TAG_BODY_LEN = 17'd9;
  localparam logic [TAG_W-1:0] TAG_CHECKSUM = 17'd10;
  localparam logic [TAG_W-1:0] TAG_MSG_TYPE = 17'd35;
  localparam logic [TAG_W-1:0] TAG_SAT      = 17'd65536;

  localparam logic [NUM_W-1:0] NUM_SAT = 32'h8000_0000;
  localparam logic [NUM_W-1:0] NUM_MAX = 32'h7fff_ffff;

  localparam logic [POS_W-1:0] CHECKSUM_DIGITS = 12'd3;

  typedef enum logic [2:0] {
    KIND_END      = 3'd0,
    KIND_GENERAL  = 3'd1,
    KIND_BEGIN    = 3'd2,
    KIND_BODY_LEN = 3'd3,
    KIND_CHECKSUM = 3'd4,
    KIND_MSG_TYPE = 3'd5
  } kind_e;

  typedef struct packed {
    logic             in_value;
    logic [TAG_W-1:0] tag_accum;
    logic             tag_done;
    logic [POS_W-1:0] byte_pos;
    logic [POS_W-1:0] value_start;
    logic [NUM_W-1:0] num_accum;
    logic             num_neg;
    logic             num_done;
    logic [15:0]      type_chars;
    logic [CNT_W-1:0] field_count;
    logic [7:0]       running_sum;
    logic [7:0]       field_start_sum;
  } state_t;

  localparam state_t STATE_RESET = '0;

  typedef struct packed {
    kind_e            field_kind;
    logic [15:0]      tag_number;
    logic [POS_W-1:0] value_offset;
    logic [POS_W-1:0] value_length;
    logic [NUM_W-1:0] number_value;
    logic [15:0]      message_type;
    logic [CNT_W-1:0] field_index;
    logic [7:0]       byte_sum;
    logic             message_end;
  } result_t;

endpackage

>>> hdl/fixtvp_in_if.sv
// ----------------------------------------------------------------------------
// fixtvp_in_if
// Byte channel into the parser: one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
interface fixtvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/fixtvp_out_if.sv
// ----------------------------------------------------------------------------
// fixtvp_out_if
// Result channel of the parser: one completed field or an end-of-message item.
// ----------------------------------------------------------------------------
interface fixtvp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         field_kind;
  logic [15:0]        tag_number;
  logic [11:0]        value_offset;
  logic [11:0]        value_length;
  logic signed [31:0] number_value;
  logic [15:0]        message_type;
  logic [10:0]        field_index;
  logic [7:0]         byte_sum;
  logic               message_end;

  modport source (output valid, output field_kind, output tag_number, output value_offset,
                  output value_length, output number_value, output message_type,
                  output field_index, output byte_sum, output message_end, input ready);
  modport sink   (input valid, input field_kind, input tag_number, input value_offset,
                  input value_length, input number_value, input message_type,
                  input field_index, input byte_sum, input message_end, output ready);
endinterface

>>> hdl/fixtvp_step.sv
// ----------------------------------------------------------------------------
// fixtvp_step
// Next-state and result logic for one message byte: tag accumulation, value
// tracking, body length / checksum decimal decode, message type packing.
// ----------------------------------------------------------------------------
module fixtvp_step #(
  parameter int MAX_MESSAGE_BYTES = fixtvp_pkg::MAX_MESSAGE_BYTES,
  parameter int MAX_FIELDS        = fixtvp_pkg::MAX_FIELDS
) (
  input  fixtvp_pkg::state_t  state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output fixtvp_pkg::state_t  state_o,
  output logic                res_valid_o,
  output fixtvp_pkg::result_t res_o
);

  localparam int POS_CAP_INT = ((MAX_MESSAGE_BYTES - 1) < 4095) ? (MAX_MESSAGE_BYTES - 1)
                                                                 : 4095;
  localparam int CNT_CAP_INT = (MAX_FIELDS < 2047) ? MAX_FIELDS : 2047;

  localparam logic [fixtvp_pkg::POS_W-1:0] POS_CAP = POS_CAP_INT[fixtvp_pkg::POS_W-1:0];
  localparam logic [fixtvp_pkg::CNT_W-1:0] CNT_CAP = CNT_CAP_INT[fixtvp_pkg::CNT_W-1:0];

  always_comb begin
    fixtvp_pkg::state_t          n;
    fixtvp_pkg::result_t         r;
    logic [7:0]                  sum_after;
    logic [fixtvp_pkg::POS_W-1:0] pos_inc;
    logic [fixtvp_pkg::POS_W-1:0] off;
    logic [fixtvp_pkg::POS_W-1:0] len_last;
    logic [fixtvp_pkg::POS_W-1:0] fin_len;
    logic                        is_digit;
    logic [3:0]                  dval;
    logic [19:0]                 tag_mul;
    logic [35:0]                 num_mul;
    logic                        fin;
    logic                        keep;

    n         = state_i;
    r         = '0;
    sum_after = state_i.running_sum + data_byte_i;
    pos_inc   = (state_i.byte_pos < POS_CAP) ? state_i.byte_pos + 1'b1 : POS_CAP;
    off       = (state_i.byte_pos >= state_i.value_start)
                ? state_i.byte_pos - state_i.value_start : '0;
    len_last  = (off == fixtvp_pkg::LEN_MAX) ? fixtvp_pkg::LEN_MAX : off + 1'b1;
    is_digit  = data_byte_i inside {[fixtvp_pkg::CHAR_0 : fixtvp_pkg::CHAR_9]};
    dval      = 4'(data_byte_i - fixtvp_pkg::CHAR_0);
    tag_mul   = 20'(state_i.tag_accum) * 20'd10 + 20'(dval);
    num_mul   = 36'(state_i.num_accum) * 36'd10 + 36'(dval);
    fin       = 1'b0;
    fin_len   = '0;

    if (!state_i.in_value) begin
      if (data_byte_i == fixtvp_pkg::CHAR_EQ) begin
        n.in_value    = 1'b1;
        n.value_start = pos_inc;
        n.num_accum   = '0;
        n.num_neg     = 1'b0;
        n.num_done    = 1'b0;
        n.type_chars  = '0;
        if (last_byte_i) begin
          fin = 1'b1;
        end
      end else if (!state_i.tag_done) begin
        if (is_digit) begin
          n.tag_accum = (tag_mul > 20'(fixtvp_pkg::TAG_SAT)) ? fixtvp_pkg::TAG_SAT
                                                              : tag_mul[fixtvp_pkg::TAG_W-1:0];
        end else begin
          n.tag_done = 1'b1;
        end
      end
    end else begin
      if (data_byte_i == fixtvp_pkg::CHAR_SOH || data_byte_i == fixtvp_pkg::CHAR_NUL) begin
        fin     = 1'b1;
        fin_len = off;
      end else begin
        if (off == 12'd0) begin
          n.type_chars = {data_byte_i, 8'h00};
        end else if (off == 12'd1) begin
          n.type_chars = state_i.type_chars | {8'h00, data_byte_i};
        end
        if (!state_i.num_done) begin
          if (state_i.tag_accum == fixtvp_pkg::TAG_BODY_LEN) begin
            if (off == 12'd0 && (data_byte_i == fixtvp_pkg::CHAR_MINUS ||
                                 data_byte_i == fixtvp_pkg::CHAR_PLUS)) begin
              n.num_neg = (data_byte_i == fixtvp_pkg::CHAR_MINUS);
            end else if (is_digit) begin
              n.num_accum = (num_mul > 36'(fixtvp_pkg::NUM_SAT)) ? fixtvp_pkg::NUM_SAT
                                                                  : num_mul[31:0];
            end else begin
              n.num_done = 1'b1;
            end
          end else if (state_i.tag_accum == fixtvp_pkg::TAG_CHECKSUM) begin
            if (off < fixtvp_pkg::CHECKSUM_DIGITS && is_digit) begin
              n.num_accum = num_mul[31:0];
            end else begin
              n.num_done = 1'b1;
            end
          end
        end
        if (last_byte_i) begin
          fin     = 1'b1;
          fin_len = len_last;
        end
      end
    end

    keep = fin && (state_i.tag_accum != '0) && !state_i.tag_accum[fixtvp_pkg::TAG_W-1];

    if (keep) begin
      r.tag_number   = state_i.tag_accum[15:0];
      r.value_offset = n.value_start;
      r.value_length = fin_len;
      r.byte_sum     = state_i.field_start_sum;
      r.message_end  = last_byte_i;
      if (state_i.tag_accum == fixtvp_pkg::TAG_BEGIN) begin
        r.field_kind = fixtvp_pkg::KIND_BEGIN;
      end else if (state_i.tag_accum == fixtvp_pkg::TAG_BODY_LEN) begin
        r.field_kind = fixtvp_pkg::KIND_BODY_LEN;
        if (n.num_neg) begin
          r.number_value = '0 - n.num_accum;
        end else begin
          r.number_value = n.num_accum[31] ? fixtvp_pkg::NUM_MAX : n.num_accum;
        end
      end else if (state_i.tag_accum == fixtvp_pkg::TAG_CHECKSUM) begin
        r.field_kind   = fixtvp_pkg::KIND_CHECKSUM;
        r.number_value = n.num_accum;
      end else if (state_i.tag_accum == fixtvp_pkg::TAG_MSG_TYPE) begin
        r.field_kind = fixtvp_pkg::KIND_MSG_TYPE;
        if (fin_len == 12'd1 || fin_len == 12'd2) begin
          r.message_type = n.type_chars;
        end
      end else begin
        r.field_kind  = fixtvp_pkg::KIND_GENERAL;
        r.field_index = state_i.field_count;
        if (state_i.field_count < CNT_CAP) begin
          n.field_count = state_i.field_count + 1'b1;
        end
      end
    end

    if (fin) begin
      n.in_value        = 1'b0;
      n.tag_accum       = '0;
      n.tag_done        = 1'b0;
      n.field_start_sum = sum_after;
    end

    n.running_sum = sum_after;
    n.byte_pos    = pos_inc;

    if (last_byte_i) begin
      if (!keep) begin
        r             = '0;
        r.field_kind  = fixtvp_pkg::KIND_END;
        r.byte_sum    = sum_after;
        r.message_end = 1'b1;
      end
      n = fixtvp_pkg::STATE_RESET;
    end

    state_o     = n;
    res_o       = r;
    res_valid_o = keep || last_byte_i;
  end

endmodule

>>> hdl/fix_tag_value_field_parser.sv
// ----------------------------------------------------------------------------
// fix_tag_value_field_parser
// Path: an accepted byte is held in the input register; its result item, if
// any, goes from the combinational byte step into the result register.
// Throughput: one byte per cycle while the result channel does not stall.
// Reset: asynchronous, active low; clears parser state and both valid flags.
// ----------------------------------------------------------------------------
module fix_tag_value_field_parser #(
  parameter int MAX_MESSAGE_BYTES = fixtvp_pkg::MAX_MESSAGE_BYTES,
  parameter int MAX_FIELDS        = fixtvp_pkg::MAX_FIELDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fixtvp_in_if.sink            in_i,
  fixtvp_out_if.source         out_o
);

  logic                in_vld_q;
  logic [7:0]          byte_q;
  logic                last_q;
  logic                out_vld_q;
  logic                out_vld_d;
  fixtvp_pkg::result_t res_q;
  fixtvp_pkg::state_t  state_q;
  fixtvp_pkg::state_t  state_d;
  fixtvp_pkg::result_t res_d;
  logic                res_valid;
  logic                advance;
  logic                in_ready;

  fixtvp_step #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
    .MAX_FIELDS        (MAX_FIELDS)
  ) u_step (
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (advance) begin
      out_vld_d = res_valid;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= fixtvp_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
    if (advance && res_valid) begin
      res_q <= res_d;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_vld_q;
  assign out_o.field_kind   = res_q.field_kind;
  assign out_o.tag_number   = res_q.tag_number;
  assign out_o.value_offset = res_q.value_offset;
  assign out_o.value_length = res_q.value_length;
  assign out_o.number_value = res_q.number_value;
  assign out_o.message_type = res_q.message_type;
  assign out_o.field_index  = res_q.field_index;
  assign out_o.byte_sum     = res_q.byte_sum;
  assign out_o.message_end  = res_q.message_end;

endmodule
